// ===== src/pgba_pkg.sv =====
// Shared types, codes and helpers of the page bitmap allocator.
`timescale 1ns / 1ps
package pgba_pkg;

  localparam int ADDR_W = 27;   // physical byte address width
  localparam int WIX_W  = 10;   // bitmap word index, wide enough for any active count
  localparam int CFG_W  = 10;   // words_in_use register width
  localparam int WORD_W = 64;   // pages per bitmap word

  typedef logic [1:0]        opcode_t;
  typedef logic [1:0]        status_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam opcode_t OP_ALLOC   = 2'd0;
  localparam opcode_t OP_FREE    = 2'd1;
  localparam opcode_t OP_RESERVE = 2'd2;
  localparam opcode_t OP_NONE    = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OOM       = 2'd1;
  localparam status_t ST_UNALIGNED = 2'd2;
  localparam status_t ST_BEYOND    = 2'd3;

  localparam cfg_t CFG_RESET = 10'd512;

  // Index of the lowest clear bit; zero when every bit is set.
  function automatic logic [5:0] lowest_zero(input word_t v);
    logic [5:0] idx;
    idx = 6'd0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ===== src/pgba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pgba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== src/page_bitmap_allocator.sv =====
// Top level of the page bitmap allocator: control, search and both bitmap memories.
`timescale 1ns / 1ps
// Physical page allocator over a bitmap in RAM; a set bit marks a used page.
// Command channel: a beat is taken when start is high and busy is low.
//   in_opcode 0 allocates the lowest free page, 1 frees the page at
//   in_page_address, 2 reserves it, 3 does nothing.
// Result channel: out_strobe marks one beat of out_granted_address and
//   out_status for exactly one cycle; the receiver cannot stall it, and the
//   next command is taken only once busy drops again.
// Config: cfg_wr_en writes cfg_wr_data into words_in_use (reset 512); write
//   it only while the block is idle.
// Storage: the bitmap RAM holds one 64-page word per entry, and a summary
//   RAM holds one "word full" flag per bitmap word, 64 flags per entry.
// Timing: a rejected, out-of-range or no-op command, and an allocate with
//   no active word, answers the cycle after it is taken. Free and reserve
//   read the bitmap word and its summary entry, then write both back.
//   Allocate scans summary entries (1 up to ceil(active words / 64)) on the
//   summary RAM read port, one entry of 64 words per cycle, then reads the
//   chosen bitmap word and writes it back; it answers OOM when all are full.
// Reset: after rst_n the block sweeps both RAMs to zero, one entry a cycle,
//   with busy high throughout; config writes are still taken.
module page_bitmap_allocator #(
  parameter int PAGE_SHIFT = 12,
  parameter int MAP_WORDS  = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pgba_pkg::opcode_t   in_opcode,
  input  pgba_pkg::addr_t     in_page_address,
  output logic                out_strobe,
  output pgba_pkg::addr_t     out_granted_address,
  output pgba_pkg::status_t   out_status,
  input  logic                cfg_wr_en,
  input  pgba_pkg::cfg_t      cfg_wr_data
);
  import pgba_pkg::*;

  localparam int SUM_DEPTH = (MAP_WORDS + WORD_W - 1) / WORD_W;
  localparam int WW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int SW        = SUM_DEPTH > 1 ? $clog2(SUM_DEPTH) : 1;
  localparam int REACH_RAW = (1 << (ADDR_W - PAGE_SHIFT)) / WORD_W;
  localparam int REACH     = REACH_RAW == 0 ? 1 : REACH_RAW;
  localparam int LIMIT     = MAP_WORDS < REACH ? MAP_WORDS : REACH;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [WW-1:0]    clr_r, clr_nxt;
  cfg_t             cfg_r, cfg_nxt;
  logic [3:0]       sidx_r, sidx_nxt;
  logic [WIX_W-1:0] wix_r, wix_nxt;
  logic [5:0]       bit_r, bit_nxt;
  logic             set_r, set_nxt;
  word_t            sumw_r, sumw_nxt;
  logic             ostb_r, ostb_nxt;
  addr_t            oaddr_r, oaddr_nxt;
  status_t          ost_r, ost_nxt;

  // RAM ports
  logic             bm_we, bm_re, sm_we, sm_re;
  logic [WW-1:0]    bm_waddr, bm_raddr;
  logic [SW-1:0]    sm_waddr, sm_raddr;
  word_t            bm_wdata, bm_rdata, sm_wdata, sm_rdata;

  // Derived request and search values
  cfg_t             active;
  logic [4:0]       nsum;
  word_t            vmask, full_m, new_w, sum_new;
  addr_t            w_full;
  logic [WIX_W-1:0] wix_in;
  logic [5:0]       b_sel, j_sel;
  logic             unaligned, beyond;

  pgba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata)
  );

  pgba_ram #(.WIDTH(WORD_W), .DEPTH(SUM_DEPTH)) u_summary (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .re(sm_re), .raddr(sm_raddr), .rdata(sm_rdata)
  );

  always_comb begin
    // Active word count: register clipped to the map and the address reach.
    active = (32'(cfg_r) < LIMIT) ? cfg_r : CFG_W'(LIMIT);
    nsum   = {1'b0, active[9:6]} + {4'd0, (active[5:0] != 6'd0)};

    // Summary flags past the active words read as full.
    if (sidx_r < active[9:6])       vmask = '1;
    else if (sidx_r == active[9:6]) vmask = (word_t'(1) << active[5:0]) - word_t'(1);
    else                            vmask = '0;
    full_m = sm_rdata | ~vmask;
    j_sel  = lowest_zero(full_m);
    b_sel  = lowest_zero(bm_rdata);

    // Decode a free or reserve address.
    unaligned = (in_page_address & addr_t'((64'(1) << PAGE_SHIFT) - 64'(1))) != '0;
    w_full    = in_page_address >> (PAGE_SHIFT + 6);
    beyond    = w_full >= addr_t'(active);
    wix_in    = WIX_W'(w_full);

    if (state_r == S_FIND) new_w = bm_rdata | (word_t'(1) << b_sel);
    else if (set_r)        new_w = bm_rdata | (word_t'(1) << bit_r);
    else                   new_w = bm_rdata & ~(word_t'(1) << bit_r);
    sum_new = sm_rdata & ~(word_t'(1) << wix_r[5:0]);
    sum_new = sum_new | (word_t'(&new_w) << wix_r[5:0]);
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cfg_nxt   = cfg_wr_en ? cfg_wr_data : cfg_r;
    sidx_nxt  = sidx_r;
    wix_nxt   = wix_r;
    bit_nxt   = bit_r;
    set_nxt   = set_r;
    sumw_nxt  = sumw_r;
    ostb_nxt  = 1'b0;
    oaddr_nxt = '0;
    ost_nxt   = ST_OK;
    bm_we     = 1'b0;
    bm_waddr  = WW'(wix_r);
    bm_wdata  = new_w;
    bm_re     = 1'b0;
    bm_raddr  = WW'(wix_in);
    sm_we     = 1'b0;
    sm_waddr  = SW'(wix_r[9:6]);
    sm_wdata  = sum_new;
    sm_re     = 1'b0;
    sm_raddr  = SW'(wix_in[9:6]);

    unique case (state_r)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        bm_wdata = '0;
        sm_we    = 32'(clr_r) < SUM_DEPTH;
        sm_waddr = SW'(clr_r);
        sm_wdata = '0;
        clr_nxt  = clr_r + WW'(1);
        if (clr_r == WW'(MAP_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_ALLOC: begin
              if (nsum == 5'd0) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_OOM;
              end else begin
                sm_re     = 1'b1;
                sm_raddr  = '0;
                sidx_nxt  = 4'd0;
                state_nxt = S_SCAN;
              end
            end
            OP_FREE, OP_RESERVE: begin
              if (unaligned) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_UNALIGNED;
              end else if (beyond) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_BEYOND;
              end else begin
                bm_re     = 1'b1;
                sm_re     = 1'b1;
                wix_nxt   = wix_in;
                bit_nxt   = 6'(in_page_address >> PAGE_SHIFT);
                set_nxt   = (in_opcode == OP_RESERVE);
                state_nxt = S_MARK;
              end
            end
            default: begin
              ostb_nxt = 1'b1;
              ost_nxt  = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (&full_m) begin
          // Advance to the next summary entry or give up.
          if ({1'b0, sidx_r} + 5'd1 == nsum) begin
            ostb_nxt  = 1'b1;
            ost_nxt   = ST_OOM;
            state_nxt = S_IDLE;
          end else begin
            sidx_nxt = sidx_r + 4'd1;
            sm_re    = 1'b1;
            sm_raddr = SW'(sidx_r + 4'd1);
          end
        end else begin
          wix_nxt   = {sidx_r, j_sel};
          sumw_nxt  = sm_rdata;
          bm_re     = 1'b1;
          bm_raddr  = WW'({sidx_r, j_sel});
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        bm_we     = 1'b1;
        sm_we     = &new_w;
        sm_wdata  = sumw_r | (word_t'(1) << wix_r[5:0]);
        ostb_nxt  = 1'b1;
        ost_nxt   = ST_OK;
        oaddr_nxt = addr_t'(64'({wix_r, b_sel}) << PAGE_SHIFT);
        state_nxt = S_IDLE;
      end
      S_MARK: begin
        // Write back the word and its full flag.
        bm_we     = 1'b1;
        sm_we     = 1'b1;
        ostb_nxt  = 1'b1;
        ost_nxt   = ST_OK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cfg_r   <= CFG_RESET;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cfg_r   <= cfg_nxt;
      ostb_r  <= ostb_nxt;
    end
    sidx_r  <= sidx_nxt;
    wix_r   <= wix_nxt;
    bit_r   <= bit_nxt;
    set_r   <= set_nxt;
    sumw_r  <= sumw_nxt;
    oaddr_r <= oaddr_nxt;
    ost_r   <= ost_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = ostb_r;
  assign out_granted_address = oaddr_r;
  assign out_status          = ost_r;

endmodule
